// File: sv/bba_pkg.sv
package bba_pkg;

  // Sizing of the map
  localparam int NUM_BLOCKS      = 1024;
  localparam int MAP_FIRST_BLOCK = 0;
  localparam int MAP_BLOCK_COUNT = 1;

  // Map word geometry: 64-bit words, narrower only for very small maps
  localparam int WORD_W    = (NUM_BLOCKS >= 64) ? 64 : 8;
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int NUM_WORDS = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int ADDR_W    = $clog2((NUM_WORDS > 1) ? NUM_WORDS : 2);
  localparam int CNT_W     = $clog2(NUM_BLOCKS + 1);

  // Reserved blocks that actually lie inside the map
  localparam int RSV_END_RAW  = MAP_FIRST_BLOCK + MAP_BLOCK_COUNT;
  localparam int RSV_END      = (RSV_END_RAW < NUM_BLOCKS) ? RSV_END_RAW : NUM_BLOCKS;
  localparam int RSV_START    = (MAP_FIRST_BLOCK < NUM_BLOCKS) ? MAP_FIRST_BLOCK : NUM_BLOCKS;
  localparam int RESERVED_USED = RSV_END - RSV_START;

  // Operation codes
  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_REQUEST = 2'd1,
    OP_RELEASE = 2'd2
  } op_t;

  // Lowest free bit of one map word
  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] bit_idx;
  } find_t;

  // Reset contents of one map word: reserved blocks set
  function automatic logic [WORD_W-1:0] word_reset(input logic [ADDR_W-1:0] addr);
    logic [WORD_W-1:0] w;
    int                blk;
    w = '0;
    for (int b = 0; b < WORD_W; b++) begin
      blk = int'(addr) * WORD_W + b;
      w[b] = (blk >= MAP_FIRST_BLOCK) && (blk < RSV_END_RAW) && (blk < NUM_BLOCKS);
    end
    return w;
  endfunction

endpackage

// File: sv/bba_ram.sv
module bba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: sv/bba_find.sv
module bba_find (
  input  logic [bba_pkg::WORD_W-1:0] word,
  input  logic [bba_pkg::ADDR_W-1:0] word_idx,
  output bba_pkg::find_t             res
);

  import bba_pkg::*;

  logic [WORD_W-1:0] in_range;
  logic [WORD_W-1:0] free_bits;
  logic [WORD_W-1:0] lowest;

  // Bits past the end of the map count as used
  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      in_range[b] = (int'(word_idx) * WORD_W + b) < NUM_BLOCKS;
    end
  end

  assign free_bits = ~word & in_range;
  // Isolate the lowest free bit
  assign lowest    = free_bits & (~free_bits + WORD_W'(1));

  // Encode the one-hot position
  always_comb begin
    res.found   = |free_bits;
    res.bit_idx = '0;
    for (int k = 0; k < BIT_W; k++) begin
      for (int b = 0; b < WORD_W; b++) begin
        if (((b >> k) & 1) == 1) begin
          res.bit_idx[k] = res.bit_idx[k] | lowest[b];
        end
      end
    end
  end

endmodule

// File: sv/bitmap_block_allocator_unit.sv
// First-fit bitmap block allocator. One used/free bit per block is kept in a
// single-port-read RAM of 64-bit words (1024 blocks = 16 words). Raise start
// with in_op/in_target_block while busy is low; exactly one result beat
// follows, marked by a one-cycle out_valid strobe that cannot be held off.
// Allocate scans the map one word per cycle from word 0 through the RAM
// read port, so its result appears once a free bit is found or the last
// word has been read, and busy drops in that same cycle. Request and
// release do one read-modify-write of the target word. Out-of-range
// targets and unknown ops answer in the next cycle without touching the
// map. After reset the block writes the reset map one word a cycle (busy
// high) before taking its first beat.
module bitmap_block_allocator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [15:0] in_target_block,
  output logic        out_valid,
  output logic        out_ok,
  output logic [9:0]  out_granted_block,
  output logic [10:0] out_used_count,
  output logic [10:0] out_free_count
);

  import bba_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_RMW   = 4'b1000
  } state_t;

  localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(NUM_WORDS - 1);
  localparam logic [16:0]       NUM_BLK17 = 17'(NUM_BLOCKS);

  state_t             state_r, state_nxt;
  logic [ADDR_W-1:0]  idx_r, idx_nxt;     // clear pointer / word in rdata
  logic [1:0]         op_r, op_nxt;
  logic [15:0]        tgt_r, tgt_nxt;
  logic [CNT_W-1:0]   used_r, used_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               ok_r, ok_nxt;
  logic [9:0]         grant_r, grant_nxt;
  logic [10:0]        ucnt_r, ucnt_nxt;
  logic [10:0]        fcnt_r, fcnt_nxt;

  logic               we;
  logic [ADDR_W-1:0]  waddr, raddr;
  logic [WORD_W-1:0]  wdata, rdata;
  find_t              fnd;

  logic               in_range;
  logic [BIT_W-1:0]   tgt_bit;
  logic [ADDR_W-1:0]  in_word;

  bba_ram #(.WIDTH(WORD_W), .DEPTH(NUM_WORDS)) u_map (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  bba_find u_find (
    .word     (rdata),
    .word_idx (idx_r),
    .res      (fnd)
  );

  assign in_range = {1'b0, in_target_block} < NUM_BLK17;
  assign in_word  = ADDR_W'(in_target_block >> BIT_W);
  assign tgt_bit  = tgt_r[BIT_W-1:0];

  // Control and read-modify-write of the map
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    op_nxt        = op_r;
    tgt_nxt       = tgt_r;
    used_nxt      = used_r;
    out_valid_nxt = 1'b0;
    ok_nxt        = ok_r;
    grant_nxt     = grant_r;
    we            = 1'b0;
    waddr         = idx_r;
    wdata         = rdata;
    raddr         = idx_r;

    case (state_r)
      ST_CLEAR: begin
        we    = 1'b1;
        wdata = word_reset(idx_r);
        if (idx_r == LAST_WORD) begin
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + ADDR_W'(1);
        end
      end

      ST_IDLE: begin
        if (start) begin
          op_nxt  = in_op;
          tgt_nxt = in_target_block;
          if (in_op == OP_ALLOC) begin
            raddr     = '0;
            idx_nxt   = '0;
            state_nxt = ST_SCAN;
          end else if ((in_op == OP_REQUEST || in_op == OP_RELEASE) && in_range) begin
            raddr     = in_word;
            idx_nxt   = in_word;
            state_nxt = ST_RMW;
          end else begin
            // out of range or unknown op: answer at once
            out_valid_nxt = 1'b1;
            ok_nxt        = 1'b0;
            grant_nxt     = '0;
          end
        end
      end

      ST_SCAN: begin
        if (fnd.found) begin
          we            = 1'b1;
          wdata         = rdata | (WORD_W'(1) << fnd.bit_idx);
          used_nxt      = used_r + CNT_W'(1);
          out_valid_nxt = 1'b1;
          ok_nxt        = 1'b1;
          grant_nxt     = 10'((32'(idx_r) << BIT_W) | 32'(fnd.bit_idx));
          state_nxt     = ST_IDLE;
        end else if (idx_r == LAST_WORD) begin
          // map full
          out_valid_nxt = 1'b1;
          ok_nxt        = 1'b0;
          grant_nxt     = '0;
          state_nxt     = ST_IDLE;
        end else begin
          raddr   = idx_r + ADDR_W'(1);
          idx_nxt = idx_r + ADDR_W'(1);
        end
      end

      ST_RMW: begin
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
        if (op_r == OP_REQUEST) begin
          if (rdata[tgt_bit]) begin
            ok_nxt    = 1'b0;
            grant_nxt = '0;
          end else begin
            we        = 1'b1;
            wdata     = rdata | (WORD_W'(1) << tgt_bit);
            used_nxt  = used_r + CNT_W'(1);
            ok_nxt    = 1'b1;
            grant_nxt = tgt_r[9:0];
          end
        end else begin
          // release: freeing a free block still succeeds
          if (rdata[tgt_bit]) begin
            we       = 1'b1;
            wdata    = rdata & ~(WORD_W'(1) << tgt_bit);
            used_nxt = used_r - CNT_W'(1);
          end
          ok_nxt    = 1'b1;
          grant_nxt = tgt_r[9:0];
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    ucnt_nxt = 11'(used_nxt);
    fcnt_nxt = 11'(CNT_W'(NUM_BLOCKS) - used_nxt);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      idx_r       <= '0;
      used_r      <= CNT_W'(RESERVED_USED);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    tgt_r   <= tgt_nxt;
    ok_r    <= ok_nxt;
    grant_r <= grant_nxt;
    ucnt_r  <= ucnt_nxt;
    fcnt_r  <= fcnt_nxt;
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_ok            = ok_r;
  assign out_granted_block = grant_r;
  assign out_used_count    = ucnt_r;
  assign out_free_count    = fcnt_r;

endmodule
